### rtl/core/lrl_pkg.sv
// ----------------------------------------------------------------------------
// lrl_pkg
// Shared constants and types for the LRU recency list.
// ----------------------------------------------------------------------------
package lrl_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TOUCH  = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    // write request to one link memory
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [SLOT_W-1:0] data;
    } link_wr_t;

endpackage

### rtl/core/lrl_ram.sv
// ----------------------------------------------------------------------------
// lrl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrl_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/lru_recency_list.sv
// ----------------------------------------------------------------------------
// lru_recency_list
// Recency order of cache slots kept as a doubly linked list in link memories.
// ----------------------------------------------------------------------------
// A request (insert or touch of one slot) is accepted only in the idle state,
// and no new request is taken until the last one's result is loaded. The
// slot's links are read at the accepting edge. Then come the unlink writes,
// the link-at-head writes, and the load of the result register. The previous
// and next links live in two small RAMs with one write port each, and that
// write port sets the sequence. The result load holds while an earlier
// result still waits on the output. The next request is accepted while a
// finished result still waits on the output. No clearing pass is needed
// after reset: only the per-slot membership bits are cleared, at once.
// An insert of an absent slot with the list at capacity evicts the tail and
// reports it; a touch of an absent slot reports an error and changes nothing.
module lru_recency_list (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: capacity
    input  logic                            cfg_we,
    input  logic [lrl_pkg::CAP_W-1:0]       cfg_wdata,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lrl_pkg::S_TDATA_W-1:0]   s_tdata,   // [3:0] slot_id
    input  logic [0:0]                      s_tuser,   // [0] opcode
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] evicted_valid, [4:1] evicted_slot, [5] touch_error, [10:6] entry_count
    output logic [lrl_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int SLOT_W = lrl_pkg::SLOT_W;
    localparam int CNT_W  = lrl_pkg::CNT_W;
    localparam int RES_W  = 2 + SLOT_W + 1 + CNT_W - 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [lrl_pkg::CAP_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [SLOT_W-1:0]          head_reg, head_next;
    logic [SLOT_W-1:0]          tail_reg, tail_next;
    logic [lrl_pkg::SLOTS-1:0]  in_list_reg, in_list_next;
    logic                       link_reg, link_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    logic                       op_reg, op_next;
    logic [SLOT_W-1:0]          sid_reg, sid_next;
    logic                       hit_reg, hit_next;
    logic                       ev_valid_reg, ev_valid_next;
    logic [SLOT_W-1:0]          ev_slot_reg, ev_slot_next;
    logic                       terr_reg, terr_next;
    logic [lrl_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [SLOT_W-1:0]          s_slot;
    logic [SLOT_W-1:0]          prev_raddr;
    logic [SLOT_W-1:0]          prev_rdata;
    logic [SLOT_W-1:0]          next_rdata;
    lrl_pkg::link_wr_t          prev_wr;
    lrl_pkg::link_wr_t          next_wr;
    logic [CNT_W-1:0]           cap_eff;
    logic                       evict;
    logic [CNT_W-1:0]           remain;

    assign s_slot = s_tdata[SLOT_W-1:0];

    // a present slot needs its own previous link; an absent insert may evict the tail
    assign prev_raddr = in_list_reg[s_slot] ? s_slot : tail_reg;

    lrl_ram #(.ADDR_W(SLOT_W), .DATA_W(SLOT_W)) u_prev_ram (
        .clk   (aclk),
        .we    (prev_wr.we),
        .waddr (prev_wr.addr),
        .wdata (prev_wr.data),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    lrl_ram #(.ADDR_W(SLOT_W), .DATA_W(SLOT_W)) u_next_ram (
        .clk   (aclk),
        .we    (next_wr.we),
        .waddr (next_wr.addr),
        .wdata (next_wr.data),
        .raddr (s_slot),
        .rdata (next_rdata)
    );

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (int'(cap_reg) > lrl_pkg::SLOTS) begin
            cap_eff = CNT_W'(lrl_pkg::SLOTS);
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign evict  = (count_reg >= cap_eff);
    assign remain = evict ? count_reg - CNT_W'(1) : count_reg;

    always_comb begin
        state_next    = state_reg;
        cap_next      = cfg_we ? cfg_wdata : cap_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        in_list_next  = in_list_reg;
        link_next     = link_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        op_next       = op_reg;
        sid_next      = sid_reg;
        hit_next      = hit_reg;
        ev_valid_next = ev_valid_reg;
        ev_slot_next  = ev_slot_reg;
        terr_next     = terr_reg;
        m_tdata_next  = m_tdata_reg;
        prev_wr       = '0;
        next_wr       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser[0];
                    sid_next   = s_slot;
                    hit_next   = in_list_reg[s_slot];
                    state_next = S_READ;
                end
            end
            S_READ: begin
                ev_valid_next = 1'b0;
                ev_slot_next  = '0;
                terr_next     = 1'b0;
                link_next     = 1'b0;
                if (hit_reg) begin
                    // head or lone entry: order already right
                    if (count_reg != CNT_W'(1) && head_reg != sid_reg) begin
                        link_next = 1'b1;
                        if (tail_reg == sid_reg) begin
                            tail_next = prev_rdata;
                        end else begin
                            // bridge the neighbors around the slot
                            next_wr = '{we: 1'b1, addr: prev_rdata, data: next_rdata};
                            prev_wr = '{we: 1'b1, addr: next_rdata, data: prev_rdata};
                        end
                    end
                end else if (op_reg == lrl_pkg::OP_TOUCH) begin
                    terr_next = 1'b1;
                end else begin
                    if (evict) begin
                        ev_valid_next          = 1'b1;
                        ev_slot_next           = tail_reg;
                        in_list_next[tail_reg] = 1'b0;
                    end
                    in_list_next[sid_reg] = 1'b1;
                    count_next            = remain + CNT_W'(1);
                    if (remain == '0) begin
                        head_next = sid_reg;
                        tail_next = sid_reg;
                    end else begin
                        link_next = 1'b1;
                        if (evict) begin
                            tail_next = prev_rdata;
                        end
                    end
                end
                state_next = S_LINK;
            end
            S_LINK: begin
                if (link_reg) begin
                    next_wr   = '{we: 1'b1, addr: sid_reg, data: head_reg};
                    prev_wr   = '{we: 1'b1, addr: head_reg, data: sid_reg};
                    head_next = sid_reg;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                // hold until the output register frees up
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = lrl_pkg::M_TDATA_W'({count_reg, terr_reg,
                                                         ev_slot_reg, ev_valid_reg});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cap_reg      <= lrl_pkg::CAP_RESET;
            count_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            in_list_reg  <= '0;
            link_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            in_list_reg  <= in_list_next;
            link_reg     <= link_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        sid_reg      <= sid_next;
        hit_reg      <= hit_next;
        ev_valid_reg <= ev_valid_next;
        ev_slot_reg  <= ev_slot_next;
        terr_reg     <= terr_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // result layout must fit the stream word
    localparam int RES_CHECK = (RES_W <= lrl_pkg::M_TDATA_W) ? 1 : 0;

    a_count_matches_members: assert property (@(posedge aclk) disable iff (!aresetn)
        (RES_CHECK == 1) && ($countones(in_list_reg) == int'(count_reg)))
        else $error("list count differs from membership bits");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= lrl_pkg::SLOTS)
        else $error("list count above slot total");

    a_ends_are_members: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && count_reg != '0) |->
            (in_list_reg[head_reg] && in_list_reg[tail_reg]))
        else $error("head or tail slot not in list");

    a_link_needs_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LINK && link_reg) |-> (count_reg >= CNT_W'(2)))
        else $error("head link issued on a list of fewer than two");

endmodule

### tb/sv/lru_recency_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_recency_check
// Watches the request, result and capacity ports of the LRU recency list,
// keeps its own linked-list copy of the recency order, and compares each
// result against the oldest predicted one. Reports the failure count and the
// number of results still owed to the testbench top.
// ----------------------------------------------------------------------------
module lru_recency_check
    import lrl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CAP_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    fail_count,
    output int                    pending_results
);

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        logic [CNT_W-1:0]  entry_count;
        logic              touch_error;
        logic [SLOT_W-1:0] evicted_slot;
        logic              evicted_valid;
    } lru_result_t;

    localparam int RES_W = $bits(lru_result_t);

    logic [SLOT_W-1:0] prev_of [SLOTS];
    logic [SLOT_W-1:0] next_of [SLOTS];
    logic              present [SLOTS];
    logic [SLOT_W-1:0] mru_slot;
    logic [SLOT_W-1:0] lru_slot;
    int unsigned       occupancy;
    logic [CAP_W-1:0]  capacity;
    lru_result_t       owed_results [$];
    int                errors = 0;

    function automatic void detach(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] p;
        logic [SLOT_W-1:0] n;
        p = prev_of[s];
        n = next_of[s];
        if (occupancy == 0) return;
        if (mru_slot == s && lru_slot == s) begin
            mru_slot = '0;
            lru_slot = '0;
        end else if (mru_slot == s) begin
            mru_slot = n;
        end else if (lru_slot == s) begin
            // tail walks back over the previous link
            lru_slot = p;
        end else begin
            next_of[p] = n;
            prev_of[n] = p;
        end
        present[s] = 1'b0;
        occupancy--;
    endfunction

    function automatic void attach_at_head(input logic [SLOT_W-1:0] s);
        if (occupancy == 0) begin
            mru_slot   = s;
            lru_slot   = s;
            prev_of[s] = s;
            next_of[s] = s;
        end else begin
            next_of[s]        = mru_slot;
            prev_of[s]        = s;
            prev_of[mru_slot] = s;
            mru_slot          = s;
        end
        present[s] = 1'b1;
        occupancy++;
    endfunction

    function automatic lru_result_t apply_request(input logic op,
                                                  input logic [SLOT_W-1:0] s);
        lru_result_t r;
        int unsigned limit;
        r = '0;
        if (capacity == 0) limit = 1;
        else if (capacity > SLOTS) limit = SLOTS;
        else limit = capacity;
        if (present[s]) begin
            // re-insert behaves as a touch
            detach(s);
            attach_at_head(s);
        end else if (op == OP_TOUCH) begin
            r.touch_error = 1'b1;
        end else begin
            // a lowered capacity evicts one per insert, never several
            if (occupancy >= limit && occupancy > 0) begin
                r.evicted_valid = 1'b1;
                r.evicted_slot  = lru_slot;
                detach(lru_slot);
            end
            attach_at_head(s);
        end
        r.entry_count = CNT_W'(occupancy);
        return r;
    endfunction

    always @(posedge aclk) begin
        lru_result_t got;
        lru_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                prev_of[i] = '0;
                next_of[i] = '0;
                present[i] = 1'b0;
            end
            mru_slot  = '0;
            lru_slot  = '0;
            occupancy = 0;
            capacity  = CAP_RESET;
            owed_results.delete();
        end else begin
            if (cfg_we) capacity = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got = lru_result_t'(m_tdata[RES_W-1:0]);
                if (owed_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: result with no request outstanding: ",
                                 $realtime,
                                 "ev=%0b slot=%0d err=%0b count=%0d",
                                 got.evicted_valid, got.evicted_slot,
                                 got.touch_error, got.entry_count);
                end else begin
                    want = owed_results.pop_front();
                    if (got.evicted_valid !== want.evicted_valid ||
                        got.evicted_slot  !== want.evicted_slot  ||
                        got.touch_error   !== want.touch_error   ||
                        got.entry_count   !== want.entry_count) begin
                        errors++;
                        if (errors <= 10)
                            $display("%t: mismatch: expected ev=%0b slot=%0d err=%0b count=%0d",
                                     $realtime, want.evicted_valid, want.evicted_slot,
                                     want.touch_error, want.entry_count,
                                     ", got ev=%0b slot=%0d err=%0b count=%0d",
                                     got.evicted_valid, got.evicted_slot,
                                     got.touch_error, got.entry_count);
                    end
                end
            end
            if (s_tvalid && s_tready)
                owed_results.push_back(apply_request(s_tuser[0], s_tdata[SLOT_W-1:0]));
        end
        fail_count      <= errors;
        pending_results <= owed_results.size();
    end

endmodule

### tb/sv/tb_lru_recency_list.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_recency_list
// Drives insert and touch requests into the LRU recency list under a series
// of capacity settings, with random idling on both sides, a long result
// stall and a full drain. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_lru_recency_list;
    import lrl_pkg::*;

    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 8;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CAP_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int                    fail_count;
    int                    pending_results;

    int unsigned           send_idle_pct  = 0;
    int unsigned           recv_idle_pct  = 0;
    logic                  holdoff_toggle = 1'b0;

    int unsigned           n_inserts  = 0;
    int unsigned           n_touches  = 0;
    int unsigned           n_settings = 0;
    logic [SLOT_W-1:0]     recent_inserts [$];

    int unsigned           phase_cap   [7] = '{1, 4, 8, 12, 20, 16, 31};
    int unsigned           phase_items [7] = '{200, 250, 300, 300, 250, 150, 150};

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    lru_recency_list dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [3:0] slot_id
        .s_tuser   (s_tuser),   // [0] opcode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // [0] evicted_valid, [4:1] evicted_slot, [5] touch_error, [10:6] entry_count
        .m_tdata   (m_tdata)
    );

    lru_recency_check lru_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        int unsigned holdoff_left;
        logic        holdoff_seen;
        if (holdoff_toggle !== holdoff_seen) begin
            holdoff_seen = holdoff_toggle;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic issue(input logic op, input logic [SLOT_W-1:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'(slot);
        do @(posedge aclk); while (!s_tready);
        if (op == OP_INSERT) begin
            n_inserts++;
            recent_inserts.push_back(slot);
            if (recent_inserts.size() > 8) void'(recent_inserts.pop_front());
        end else begin
            n_touches++;
        end
    endtask

    // drop valid and hold until every owed result is back or the drain limit is reached
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        n_settings++;
    endtask

    task automatic random_request();
        logic              op;
        logic [SLOT_W-1:0] slot;
        op = ($urandom_range(99) < 55) ? OP_INSERT : OP_TOUCH;
        // most touches aim at recently inserted slots so they hit
        if (op == OP_TOUCH && recent_inserts.size() != 0 && $urandom_range(3) != 0)
            slot = recent_inserts[$urandom_range(recent_inserts.size() - 1)];
        else
            slot = SLOT_W'($urandom_range(SLOTS - 1));
        issue(op, slot);
    endtask

    initial begin : stimulus
        int unsigned rand_idx;
        rand_idx = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 12;
        recv_idle_pct <= 76;

        // reset capacity: empty list, re-inserts, head and tail moves
        issue(OP_TOUCH,  4'd3);
        issue(OP_INSERT, 4'd0);
        issue(OP_INSERT, 4'd15);
        issue(OP_INSERT, 4'd0);
        issue(OP_INSERT, 4'd0);
        issue(OP_TOUCH,  4'd15);
        issue(OP_TOUCH,  4'd15);
        issue(OP_TOUCH,  4'd9);
        issue(OP_INSERT, 4'd9);
        issue(OP_TOUCH,  4'd0);
        issue(OP_TOUCH,  4'd15);

        // zero acts as one, already below the count
        wait_idle();
        write_capacity('0);
        issue(OP_INSERT, 4'd4);
        issue(OP_INSERT, 4'd5);
        issue(OP_TOUCH,  4'd4);
        issue(OP_TOUCH,  4'd9);

        // above the slot count acts as full size
        wait_idle();
        write_capacity('1);
        issue(OP_INSERT, 4'd12);
        issue(OP_INSERT, 4'd10);
        issue(OP_TOUCH,  4'd12);
        issue(OP_INSERT, 4'd5);

        // low capacities first: the count never shrinks
        for (int p = 0; p < 7; p++) begin
            wait_idle();
            write_capacity(CAP_W'(phase_cap[p]));
            for (int i = 0; i < phase_items[p]; i++) begin
                if (rand_idx == 533) begin
                    send_idle_pct = 76;
                    recv_idle_pct <= 12;
                end
                if (rand_idx == 1066) begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
                if (rand_idx == 800) wait_idle();
                if (rand_idx == 1150) holdoff_toggle <= ~holdoff_toggle;
                random_request();
                rand_idx++;
            end
        end

        wait_idle();
        $display("Sent %0d inserts and %0d touches under %0d capacity writes,",
                 n_inserts, n_touches, n_settings);
        $display("including a %0d-cycle result stall and full drains between settings.",
                 HOLDOFF_CYCLES);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
